>>> hdl/websocket_frame_unmasker_macros.svh
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_macros.svh
// Assertion shorthands shared by the frame unmasker RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_UNMASKER_MACROS_SVH
`define WEBSOCKET_FRAME_UNMASKER_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define WSFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define WSFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wsfu_pkg.sv
// ----------------------------------------------------------------------------
// wsfu_pkg
// Types and constants shared by the frame unmasker modules.
// ----------------------------------------------------------------------------
package wsfu_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT_HI  = 3'd2,
    PH_EXT_LO  = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic        fin;
    logic        last_byte;
  } result_t;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

endpackage

>>> hdl/wsfu_core.sv
// ----------------------------------------------------------------------------
// wsfu_core
// Frame header parser state and payload unmask for one byte per step.
// ----------------------------------------------------------------------------
module wsfu_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              buffer_start,
  output logic              res_valid,
  output wsfu_pkg::result_t res
);
  import wsfu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  frame_opcode_r, frame_opcode_nxt;
  logic        frame_fin_r, frame_fin_nxt;
  logic        mask_present_r, mask_present_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [1:0]  key_index_r, key_index_nxt;

  phase_t      ph;
  logic [1:0]  kidx;
  logic        len_known;
  logic [15:0] len_val;
  logic        hdr_done;
  logic [15:0] hdr_rem;
  logic [7:0]  key_byte;
  logic [15:0] rem_dec;

  always_comb begin
    phase_nxt        = phase_r;
    frame_opcode_nxt = frame_opcode_r;
    frame_fin_nxt    = frame_fin_r;
    mask_present_nxt = mask_present_r;
    length_high_nxt  = length_high_r;
    remaining_nxt    = remaining_r;
    mask_key_nxt     = mask_key_r;
    len_known        = 1'b0;
    len_val          = 16'd0;
    hdr_done         = 1'b0;
    hdr_rem          = remaining_r;
    rem_dec          = remaining_r - 16'd1;
    res_valid        = 1'b0;
    res.kind         = KIND_DATA;
    res.payload_byte = 8'd0;
    res.opcode       = frame_opcode_r;
    res.fin          = frame_fin_r;
    res.last_byte    = 1'b0;

    // A new buffer restarts the parse with this byte as header byte zero.
    ph   = buffer_start ? PH_HDR0 : phase_r;
    kidx = buffer_start ? 2'd0 : key_index_r;
    key_index_nxt = kidx;
    key_byte = mask_key_r[{~kidx, 3'b000} +: 8];

    case (ph)
      PH_HDR0: begin
        frame_fin_nxt    = data_byte[7];
        frame_opcode_nxt = data_byte[3:0];
        phase_nxt        = PH_HDR1;
      end
      PH_HDR1: begin
        mask_present_nxt = data_byte[7];
        if (data_byte[6:0] == LEN_EXT16) begin
          phase_nxt = PH_EXT_HI;
        end else if (data_byte[6:0] == LEN_EXT64) begin
          phase_nxt = PH_DISCARD;
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
        end else begin
          len_known = 1'b1;
          len_val   = {9'd0, data_byte[6:0]};
        end
      end
      PH_EXT_HI: begin
        length_high_nxt = data_byte;
        phase_nxt       = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        len_known = 1'b1;
        len_val   = {length_high_r, data_byte};
      end
      PH_KEY: begin
        mask_key_nxt[{~kidx, 3'b000} +: 8] = data_byte;
        key_index_nxt = kidx + 2'd1;
        hdr_done      = (kidx == 2'd3);
      end
      PH_PAYLOAD: begin
        key_index_nxt    = kidx + 2'd1;
        remaining_nxt    = rem_dec;
        res_valid        = 1'b1;
        res.payload_byte = mask_present_r ? (data_byte ^ key_byte) : data_byte;
        if (rem_dec == 16'd0) begin
          phase_nxt     = PH_HDR0;
          key_index_nxt = 2'd0;
          res.last_byte = 1'b1;
        end
      end
      default: begin
        // Discarding until the next buffer start; unused codes behave alike.
        phase_nxt = ph;
      end
    endcase

    if (len_known) begin
      remaining_nxt = len_val;
      if (mask_present_nxt) begin
        key_index_nxt = 2'd0;
        mask_key_nxt  = 32'd0;
        phase_nxt     = PH_KEY;
      end else begin
        hdr_done = 1'b1;
        hdr_rem  = len_val;
      end
    end

    if (hdr_done) begin
      key_index_nxt = 2'd0;
      if (hdr_rem == 16'd0) begin
        phase_nxt = PH_HDR0;
        res_valid = 1'b1;
        res.kind  = KIND_EMPTY;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HDR0;
      frame_opcode_r <= 4'd0;
      frame_fin_r    <= 1'b0;
      mask_present_r <= 1'b0;
      length_high_r  <= 8'd0;
      remaining_r    <= 16'd0;
      mask_key_r     <= 32'd0;
      key_index_r    <= 2'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      frame_opcode_r <= frame_opcode_nxt;
      frame_fin_r    <= frame_fin_nxt;
      mask_present_r <= mask_present_nxt;
      length_high_r  <= length_high_nxt;
      remaining_r    <= remaining_nxt;
      mask_key_r     <= mask_key_nxt;
      key_index_r    <= key_index_nxt;
    end
  end

`include "websocket_frame_unmasker_macros.svh"

  `WSFU_ASSERT_IMP(a_payload_nonzero, phase_r == PH_PAYLOAD, remaining_r != 16'd0, "payload phase with no bytes left")
  `WSFU_ASSERT_NXT(a_start_restarts, step && buffer_start, phase_r == PH_HDR1, "buffer start did not restart the header parse")
  `WSFU_ASSERT_IMP(a_nondata_clean, res_valid && res.kind != KIND_DATA, res.payload_byte == 8'd0 && !res.last_byte, "non-data result carries payload bits")
  `WSFU_ASSERT_NXT(a_last_ends_frame, step && res_valid && res.last_byte, phase_r == PH_HDR0 && key_index_r == 2'd0, "last payload byte did not end the frame")

endmodule

>>> hdl/websocket_frame_unmasker.sv
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Byte-serial frame header parser and payload unmasker.
// ----------------------------------------------------------------------------
// A byte accepted into the input register is parsed when the single parse
// stage steps; its result is then registered and offered until it is taken.
// Throughput: one byte per cycle, set by that stage, unless out_stall holds a result.
// Reset: synchronous active-low rst_n clears the pipeline valids and the
// parser state, which returns to reading the first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_buffer_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic [3:0] out_opcode,
  output logic       out_fin,
  output logic       out_last_byte
);
  import wsfu_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       out_valid_r;
  result_t    out_res_r;

  logic       advance;
  logic       step;
  logic       res_valid;
  result_t    res;

  // The parse stage moves whenever the result register is empty or drains.
  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_v_r && advance;
  assign in_stall = in_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r  <= in_data_byte;
      in_start_r <= in_buffer_start;
    end
  end

  wsfu_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (in_byte_r),
    .buffer_start (in_start_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_opcode       = out_res_r.opcode;
  assign out_fin          = out_res_r.fin;
  assign out_last_byte    = out_res_r.last_byte;

endmodule
